// ----- src/kslm_pkg.sv -----
// kslm_pkg: shared types and constants of the keepalive session link manager.
// Holds the transaction structs, the op and tx kind codes, and the link state
// enum. Depends on nothing.
package kslm_pkg;

  localparam logic [2:0] OP_TICK_BEGIN = 3'd0;
  localparam logic [2:0] OP_TICK_END   = 3'd1;
  localparam logic [2:0] OP_HELLO      = 3'd2;
  localparam logic [2:0] OP_KEEPALIVE  = 3'd3;
  localparam logic [2:0] OP_DATA       = 3'd4;
  localparam logic [2:0] OP_RESET      = 3'd5;
  localparam logic [2:0] OP_SEND       = 3'd6;
  localparam logic [2:0] OP_ILLEGAL    = 3'd7;

  localparam logic [2:0] TX_NONE      = 3'd0;
  localparam logic [2:0] TX_HELLO     = 3'd1;
  localparam logic [2:0] TX_KEEPALIVE = 3'd2;
  localparam logic [2:0] TX_RESET     = 3'd3;
  localparam logic [2:0] TX_DATA      = 3'd4;

  localparam logic CFG_IS_SERVER        = 1'b0;
  localparam logic CFG_START_SESSION_ID = 1'b1;

  localparam logic [15:0] KA_INTERVAL_DEFAULT  = 16'd5;
  localparam logic [15:0] KA_TOLERANCE_DEFAULT = 16'd5;

  localparam logic [1:0] SS_DOWN      = 2'd0;
  localparam logic [1:0] SS_INIT      = 2'd1;
  localparam logic [1:0] SS_UP        = 2'd2;
  localparam logic [1:0] SS_RESETTING = 2'd3;

  typedef enum logic [3:0] {
    LS_DOWN      = 4'b0001,
    LS_INIT      = 4'b0010,
    LS_UP        = 4'b0100,
    LS_RESETTING = 4'b1000
  } link_state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] timestamp;
    logic [31:0] msg_session_id;
    logic [31:0] msg_sequence;
    logic        has_interval;
    logic [15:0] new_interval;
    logic        has_tolerance;
    logic [15:0] new_tolerance;
    logic        tx_accept;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  tx_kind;
    logic [31:0] tx_session_id;
    logic [31:0] tx_sequence;
    logic [15:0] tx_interval;
    logic [15:0] tx_tolerance;
    logic        established;
    logic        disconnected;
    logic        deliver;
    logic        send_failed;
    logic        link_down;
    logic [1:0]  link_status;
    logic        last;
  } rsp_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] sid;
    logic [31:0] seq;
    logic [15:0] ival;
    logic [15:0] tol;
  } tx_t;

  typedef struct packed {
    logic established;
    logic disconnected;
    logic deliver;
    logic send_failed;
    logic link_down;
  } status_t;

  // One classified step as it travels from front to back.
  typedef struct packed {
    logic        dual;
    tx_t         tx0;
    tx_t         tx1;
    status_t     status;
    logic [1:0]  state;
  } step_rec_t;

  function automatic logic [1:0] state_code(link_state_t s);
    logic [1:0] c;
    unique case (s)
      LS_DOWN:      c = SS_DOWN;
      LS_INIT:      c = SS_INIT;
      LS_UP:        c = SS_UP;
      LS_RESETTING: c = SS_RESETTING;
      default:      c = SS_DOWN;
    endcase
    return c;
  endfunction

endpackage

// ----- src/keepalive_session_link_manager_unit.sv -----
// keepalive_session_link_manager_unit: top level of the session link manager.
// Response transactions leave from the back's output register after the queue.
// Throughput: one request per cycle while the queue is not full; a tick begin
// that sends hello and keepalive holds the output register for both of them.
// Reset: synchronous rst sets the link down, session id and registers to 0,
// interval and tolerance to 5, and empties the queue. Depends on kslm_pkg.
module keepalive_session_link_manager_unit import kslm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_item_t   req_data,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_item_t   rsp_data,
  // configuration writes, only while idle
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // Front: state update and step classification in the accept cycle.
  // Queue: two records, so the front keeps accepting while the back waits.
  // Back: output register, splits a record into one or two transactions.

  step_rec_t front_rec;
  step_rec_t head_rec;
  logic      take;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;

  // stall comes only from queue occupancy, never from the request valid
  assign req_stall = q_full;
  assign take      = req_valid && !q_full;

  kslm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .req       (req_data),
    .rec       (front_rec)
  );

  kslm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_rec  (front_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_rec)
  );

  kslm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_not_empty),
    .rec       (head_rec),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

// ----- src/kslm_front.sv -----
// kslm_front: accepts request transactions, holds the session state and
// classifies each step into a step record. Depends on kslm_pkg.
module kslm_front import kslm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        take,
  input  req_item_t   req,
  output step_rec_t   rec
);

  typedef struct packed {
    link_state_t state;
    logic [31:0] sess;
    logic        est;
    logic        disc;
  } ctx_t;

  function automatic ctx_t go_to(ctx_t c, link_state_t ns);
    ctx_t r;
    r = c;
    r.state = ns;
    if (c.state != ns && ns == LS_DOWN) r.sess = c.sess + 32'd1;
    if (c.state != LS_UP && ns == LS_UP) r.est = 1'b1;
    else if (c.state == LS_UP && ns != LS_UP) r.disc = 1'b1;
    return r;
  endfunction

  function automatic tx_t mk_tx(logic [2:0] k, logic [31:0] sid, logic [31:0] seq,
                                logic [15:0] iv, logic [15:0] tl);
    tx_t t;
    t.kind = k;
    t.sid  = sid;
    t.seq  = seq;
    t.ival = iv;
    t.tol  = tl;
    return t;
  endfunction

  logic        server_mode;
  link_state_t link_state;
  logic [31:0] current_session;
  logic [31:0] expected_in_seq;
  logic [31:0] sent_out_seq;
  logic [15:0] ka_interval;
  logic [15:0] ka_tolerance;
  logic [31:0] last_sent_time;
  logic [31:0] last_heard_time;

  ctx_t        ctx_next;
  logic [31:0] expected_in_seq_next;
  logic [31:0] sent_out_seq_next;
  logic [15:0] ka_interval_next;
  logic [15:0] ka_tolerance_next;
  logic [31:0] last_sent_time_next;
  logic [31:0] last_heard_time_next;

  logic [31:0] delta;
  logic [31:0] heard_gap;
  logic [31:0] limit;
  logic        due;
  logic        hello_sent;
  logic [31:0] in_seq_inc;

  assign delta      = req.timestamp - last_sent_time;
  assign heard_gap  = req.timestamp - last_heard_time;
  assign limit      = {16'b0, ka_interval} * {16'b0, ka_tolerance};
  assign due        = delta >= {16'b0, ka_interval};
  assign in_seq_inc = expected_in_seq + 32'd1;

  always_comb begin
    ctx_next.state       = link_state;
    ctx_next.sess        = current_session;
    ctx_next.est         = 1'b0;
    ctx_next.disc        = 1'b0;
    expected_in_seq_next = expected_in_seq;
    sent_out_seq_next    = sent_out_seq;
    ka_interval_next     = ka_interval;
    ka_tolerance_next    = ka_tolerance;
    last_sent_time_next  = last_sent_time;
    last_heard_time_next = last_heard_time;
    hello_sent           = 1'b0;
    rec                  = '0;

    unique case (req.op)
      OP_TICK_BEGIN: begin
        if (link_state == LS_DOWN && due && !server_mode) begin
          rec.tx0 = mk_tx(TX_HELLO, current_session, 32'd0, ka_interval, ka_tolerance);
          hello_sent = 1'b1;
          if (req.tx_accept) begin
            expected_in_seq_next = '0;
            sent_out_seq_next    = '0;
            ctx_next = go_to(ctx_next, LS_INIT);
          end
          last_sent_time_next  = req.timestamp;
          last_heard_time_next = req.timestamp;
        end
        // keepalive when due and not down, also after a hello into init
        if (ctx_next.state != LS_DOWN && due) begin
          if (hello_sent) begin
            rec.dual = 1'b1;
            rec.tx1  = mk_tx(TX_KEEPALIVE, ctx_next.sess, 32'd0, 16'd0, 16'd0);
          end else begin
            rec.tx0  = mk_tx(TX_KEEPALIVE, ctx_next.sess, 32'd0, 16'd0, 16'd0);
          end
          last_sent_time_next = req.timestamp;
        end
      end
      OP_TICK_END: begin
        if (link_state != LS_DOWN && heard_gap > limit)
          ctx_next = go_to(ctx_next, LS_RESETTING);
        if (ctx_next.state == LS_RESETTING) begin
          ctx_next = go_to(ctx_next, LS_DOWN);
          if (server_mode)
            rec.tx0 = mk_tx(TX_RESET, ctx_next.sess, 32'd0, 16'd0, 16'd0);
        end
        rec.status.link_down = (ctx_next.state == LS_DOWN);
      end
      OP_HELLO: begin
        // repeated hello of a live session with no data yet is dropped
        if (!(link_state != LS_DOWN && current_session == req.msg_session_id &&
              expected_in_seq == 32'd0)) begin
          expected_in_seq_next = '0;
          sent_out_seq_next    = '0;
          ctx_next.sess        = req.msg_session_id;
          if (req.has_interval)  ka_interval_next  = req.new_interval;
          if (req.has_tolerance) ka_tolerance_next = req.new_tolerance;
          last_heard_time_next = req.timestamp;
          ctx_next = go_to(ctx_next, LS_INIT);
          rec.tx0  = mk_tx(TX_KEEPALIVE, req.msg_session_id, 32'd0, 16'd0, 16'd0);
          last_sent_time_next = req.timestamp;
        end
      end
      OP_KEEPALIVE: begin
        if ((link_state == LS_INIT || link_state == LS_UP) &&
            current_session == req.msg_session_id) begin
          last_heard_time_next = req.timestamp;
          if (link_state == LS_INIT) begin
            rec.tx0 = mk_tx(TX_KEEPALIVE, current_session, 32'd0, 16'd0, 16'd0);
            last_sent_time_next = req.timestamp;
          end
          ctx_next = go_to(ctx_next, LS_UP);
        end
      end
      OP_DATA: begin
        if (link_state == LS_UP && current_session == req.msg_session_id) begin
          expected_in_seq_next = in_seq_inc;
          if (req.msg_sequence != in_seq_inc) begin
            ctx_next = go_to(ctx_next, LS_RESETTING);
          end else begin
            rec.status.deliver   = 1'b1;
            last_heard_time_next = req.timestamp;
          end
        end
      end
      OP_RESET: begin
        ctx_next = go_to(ctx_next, LS_RESETTING);
      end
      OP_SEND: begin
        if (link_state != LS_UP) begin
          rec.status.send_failed = 1'b1;
        end else begin
          rec.tx0 = mk_tx(TX_DATA, current_session, sent_out_seq + 32'd1, 16'd0, 16'd0);
          if (req.tx_accept) sent_out_seq_next = sent_out_seq + 32'd1;
          else               rec.status.send_failed = 1'b1;
        end
      end
      default: begin
        // illegal message: no change
      end
    endcase

    rec.status.established  = ctx_next.est;
    rec.status.disconnected = ctx_next.disc;
    rec.state               = state_code(ctx_next.state);
  end

  // A start session id write only loads the session counter; after reset
  // the register reads zero, which is the counter's reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      server_mode      <= 1'b0;
      link_state       <= LS_DOWN;
      current_session  <= '0;
      expected_in_seq  <= '0;
      sent_out_seq     <= '0;
      ka_interval      <= KA_INTERVAL_DEFAULT;
      ka_tolerance     <= KA_TOLERANCE_DEFAULT;
      last_sent_time   <= '0;
      last_heard_time  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IS_SERVER:        server_mode     <= cfg_data[0];
        CFG_START_SESSION_ID: current_session <= cfg_data;
        default: ;
      endcase
    end else if (take) begin
      link_state      <= ctx_next.state;
      current_session <= ctx_next.sess;
      expected_in_seq <= expected_in_seq_next;
      sent_out_seq    <= sent_out_seq_next;
      ka_interval     <= ka_interval_next;
      ka_tolerance    <= ka_tolerance_next;
      last_sent_time  <= last_sent_time_next;
      last_heard_time <= last_heard_time_next;
    end
  end

endmodule

// ----- src/kslm_queue.sv -----
// kslm_queue: two-entry queue of step records between front and back.
// Depends on kslm_pkg.
module kslm_queue import kslm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_rec_t push_rec,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output step_rec_t head
);

  step_rec_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/kslm_back.sv -----
// kslm_back: takes step records from the queue and sends them out as one
// or two response transactions from an output register. Depends on kslm_pkg.
module kslm_back import kslm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      rec_valid,
  input  step_rec_t rec,
  output logic      pop,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp_data
);

  logic      have;
  logic      phase;
  step_rec_t cur;
  logic      first_of_two;
  logic      item_done;
  logic      advance;
  tx_t       tx_sel;

  assign first_of_two = cur.dual && !phase;
  assign item_done    = have && !rsp_stall;
  assign advance      = !have || (item_done && !first_of_two);
  assign pop          = advance && rec_valid;
  assign rsp_valid    = have;
  assign tx_sel       = phase ? cur.tx1 : cur.tx0;

  always_comb begin
    rsp_data.tx_kind       = tx_sel.kind;
    rsp_data.tx_session_id = tx_sel.sid;
    rsp_data.tx_sequence   = tx_sel.seq;
    rsp_data.tx_interval   = tx_sel.ival;
    rsp_data.tx_tolerance  = tx_sel.tol;
    rsp_data.link_status   = cur.state;
    // status pulses ride on the final transaction only
    rsp_data.established   = first_of_two ? 1'b0 : cur.status.established;
    rsp_data.disconnected  = first_of_two ? 1'b0 : cur.status.disconnected;
    rsp_data.deliver       = first_of_two ? 1'b0 : cur.status.deliver;
    rsp_data.send_failed   = first_of_two ? 1'b0 : cur.status.send_failed;
    rsp_data.link_down     = first_of_two ? 1'b0 : cur.status.link_down;
    rsp_data.last          = !first_of_two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have  <= 1'b0;
      phase <= 1'b0;
    end else if (item_done && first_of_two) begin
      phase <= 1'b1;
    end else if (advance) begin
      have  <= rec_valid;
      phase <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= rec;
  end

endmodule
